// ===== hdl/rmac_pkg.sv =====
// package for the region map access checker
// holds operation and status codes and the controller/datapath handshake types
// no dependencies
`default_nettype none
package rmac_pkg;

	localparam int RegionsDefault = 16;

	localparam logic [2:0] KIND_MAP     = 3'd0;
	localparam logic [2:0] KIND_UNMAP   = 3'd1;
	localparam logic [2:0] KIND_PROTECT = 3'd2;
	localparam logic [2:0] KIND_READ    = 3'd3;
	localparam logic [2:0] KIND_WRITE   = 3'd4;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_EMPTY    = 3'd1;
	localparam logic [2:0] ST_OVERFLOW = 3'd2;
	localparam logic [2:0] ST_LIMIT    = 3'd3;
	localparam logic [2:0] ST_OVERLAP  = 3'd4;
	localparam logic [2:0] ST_MISSING  = 3'd5;
	localparam logic [2:0] ST_DENIED   = 3'd6;

	localparam logic [3:0] REG_MAX_MAPPED = 4'd0;

	// commands from controller to datapath
	typedef struct packed {
		logic capture;
		logic prep;
		logic rd_en;
		logic finish;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic pre_fail;
		logic out_busy;
	} sts_t;

endpackage
`default_nettype wire

// ===== hdl/region_map_access_checker.sv =====
// top level of the region map access checker: apb decode and the two halves
// depends on rmac_pkg, rmac_ctrl, rmac_dp
//
//  channel | signals                                   | transfer when
//  input   | in_valid/in_ready, kind..skip_perm_check  | in_valid && in_ready
//  output  | out_valid/out_ready, status..mapped_total | out_valid && out_ready
//  config  | psel/penable/pwrite/paddr/pwdata/prdata   | psel && penable && pwrite
//
// one operation runs through setup, one table read per region through the single
// read port, drain and write-back.
// a map rejected by its prechecks skips the table reads and the drain.
// reset clears valid bits, byte total and the limit (all ones); no clearing pass.
// a stalled output holds the finished result; the next item is taken meanwhile.
`default_nettype none
module region_map_access_checker #(
	parameter int REGIONS = rmac_pkg::RegionsDefault
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  kind,
	input  wire logic [63:0] address,
	input  wire logic [63:0] length,
	input  wire logic [7:0]  perm_bits,
	input  wire logic        skip_perm_check,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       status,
	output logic [3:0]       slot,
	output logic [63:0]      offset,
	output logic [63:0]      mapped_total,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic [63:0]      prdata,
	output logic             pready
);
	import rmac_pkg::*;

	localparam int IdxW = (REGIONS > 1) ? $clog2(REGIONS) : 1;

	cmd_t            cmd;
	sts_t            sts;
	logic [IdxW-1:0] rd_addr;
	logic            cfg_we;
	logic [63:0]     max_bytes;

	// apb decode
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && (paddr == REG_MAX_MAPPED);
	assign prdata = (paddr == REG_MAX_MAPPED) ? max_bytes : '0;

	rmac_ctrl #(.REGIONS(REGIONS)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd),
		.rd_addr  (rd_addr)
	);

	rmac_dp #(.REGIONS(REGIONS)) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.rd_addr         (rd_addr),
		.sts             (sts),
		.kind            (kind),
		.address         (address),
		.length          (length),
		.perm_bits       (perm_bits),
		.skip_perm_check (skip_perm_check),
		.cfg_we          (cfg_we),
		.cfg_wdata       (pwdata),
		.max_bytes       (max_bytes),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.status          (status),
		.slot            (slot),
		.offset          (offset),
		.mapped_total    (mapped_total)
	);
endmodule
`default_nettype wire

// ===== hdl/rmac_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`default_nettype none
module rmac_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic                                  re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

// ===== hdl/rmac_ctrl.sv =====
// sequencing state machine for the region map access checker
// depends on rmac_pkg
`default_nettype none
module rmac_ctrl #(
	parameter int REGIONS = rmac_pkg::RegionsDefault
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire rmac_pkg::sts_t       sts,
	output rmac_pkg::cmd_t            cmd,
	output logic [((REGIONS > 1) ? $clog2(REGIONS) : 1)-1:0] rd_addr
);
	import rmac_pkg::*;

	localparam int IdxW = (REGIONS > 1) ? $clog2(REGIONS) : 1;
	localparam logic [IdxW-1:0] LastIdx = IdxW'(REGIONS - 1);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_PREP   = 5'b00010,
		S_SCAN   = 5'b00100,
		S_DRAIN  = 5'b01000,
		S_FINISH = 5'b10000
	} state_t;

	state_t          state_q;
	logic [IdxW-1:0] cnt_q;

	assign in_ready = (state_q == S_IDLE);
	assign rd_addr  = cnt_q;

	// command decode
	always_comb begin
		cmd.capture = in_valid && in_ready;
		cmd.prep    = (state_q == S_PREP);
		cmd.rd_en   = (state_q == S_SCAN) && !sts.pre_fail;
		cmd.finish  = (state_q == S_FINISH);
	end

	// state and scan counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (in_valid) begin
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (sts.pre_fail) begin
						state_q <= S_FINISH;
					end else if (cnt_q == LastIdx) begin
						state_q <= S_DRAIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_DRAIN: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (!sts.out_busy) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	// scan only runs in its own state
	a_rd_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |-> state_q == S_SCAN)
		else $error("read issued outside scan");
	// a new transfer is taken only when idle
	a_cap_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> state_q == S_PREP)
		else $error("capture did not start prep");
	// drain always follows the last scan read
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DRAIN) |-> $past(cnt_q) == LastIdx)
		else $error("drain before scan end");
`endif
endmodule
`default_nettype wire

// ===== hdl/rmac_dp.sv =====
// datapath: operand registers, region table, scan evaluation, result register
// depends on rmac_pkg and rmac_ram
`default_nettype none
module rmac_dp #(
	parameter int REGIONS = rmac_pkg::RegionsDefault
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire rmac_pkg::cmd_t       cmd,
	input  wire logic [((REGIONS > 1) ? $clog2(REGIONS) : 1)-1:0] rd_addr,
	output rmac_pkg::sts_t            sts,
	input  wire logic [2:0]           kind,
	input  wire logic [63:0]          address,
	input  wire logic [63:0]          length,
	input  wire logic [7:0]           perm_bits,
	input  wire logic                 skip_perm_check,
	input  wire logic                 cfg_we,
	input  wire logic [63:0]          cfg_wdata,
	output logic      [63:0]          max_bytes,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic      [2:0]           status,
	output logic      [3:0]           slot,
	output logic      [63:0]          offset,
	output logic      [63:0]          mapped_total
);
	import rmac_pkg::*;

	localparam int IdxW = (REGIONS > 1) ? $clog2(REGIONS) : 1;
	localparam int EntW = 64 + 64 + 8;

	// operand registers
	logic [2:0]  kind_q;
	logic [63:0] addr_q, len_q;
	logic [7:0]  perm_q;
	logic        skip_q;
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= kind;
			addr_q <= address;
			len_q  <= length;
			perm_q <= perm_bits;
			skip_q <= skip_perm_check;
		end
	end

	// control state: limit, byte total, valid bits
	logic [63:0]  max_q, bytes_q;
	logic [REGIONS-1:0] valid_q;

	// map prechecks
	logic [64:0] end_sum, tot_sum;
	logic [63:0] end_q, total_q;
	logic        pre_fail_q;
	logic [2:0]  pre_st_q;
	assign end_sum = {1'b0, addr_q} + {1'b0, len_q};
	assign tot_sum = {1'b0, bytes_q} + {1'b0, len_q};
	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			end_q   <= end_sum[63:0];
			total_q <= tot_sum[63:0];
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_fail_q <= 1'b0;
			pre_st_q   <= ST_OK;
		end else if (cmd.prep) begin
			if (kind_q != KIND_MAP) begin
				pre_fail_q <= 1'b0;
				pre_st_q   <= ST_OK;
			end else if (len_q == '0) begin
				pre_fail_q <= 1'b1;
				pre_st_q   <= ST_EMPTY;
			end else if (end_sum[64] || end_sum[63:0] == '0) begin
				pre_fail_q <= 1'b1;
				pre_st_q   <= ST_OVERFLOW;
			end else if (tot_sum[64] || tot_sum[63:0] > max_q) begin
				pre_fail_q <= 1'b1;
				pre_st_q   <= ST_LIMIT;
			end else begin
				pre_fail_q <= 1'b0;
				pre_st_q   <= ST_OK;
			end
		end
	end

	// region table
	logic            ram_we;
	logic [IdxW-1:0] ram_waddr;
	logic [EntW-1:0] ram_wdata, ram_rdata;
	rmac_ram #(.WIDTH(EntW), .DEPTH(REGIONS)) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.rd_en),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	// scan pipeline stage aligned with read data
	logic            eval_s1;
	logic [IdxW-1:0] idx_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eval_s1 <= 1'b0;
		end else begin
			eval_s1 <= cmd.rd_en;
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			idx_s1 <= rd_addr;
		end
	end

	// per-entry evaluation
	logic [63:0] eb, es, diff;
	logic [7:0]  ep;
	logic [64:0] ent_end;
	logic        ev, hit, ovl;
	always_comb begin
		eb      = ram_rdata[EntW-1 -: 64];
		es      = ram_rdata[71:8];
		ep      = ram_rdata[7:0];
		ev      = valid_q[idx_s1];
		diff    = addr_q - eb;
		ent_end = {1'b0, eb} + {1'b0, es};
		ovl     = ({1'b0, addr_q} < ent_end) && (eb < end_q);
		if (kind_q == KIND_UNMAP || kind_q == KIND_PROTECT) begin
			hit = ev && (eb == addr_q);
		end else begin
			hit = ev && (addr_q >= eb) && (diff < es);
		end
	end

	// scan accumulators
	logic            found_q, overlap_q, free_q;
	logic [IdxW-1:0] hit_slot_q, free_slot_q;
	logic [63:0]     hit_size_q, hit_off_q;
	logic [7:0]      hit_perm_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q   <= 1'b0;
			overlap_q <= 1'b0;
			free_q    <= 1'b0;
		end else if (cmd.capture) begin
			found_q   <= 1'b0;
			overlap_q <= 1'b0;
			free_q    <= 1'b0;
		end else if (eval_s1) begin
			if (hit && !found_q) begin
				found_q <= 1'b1;
			end
			if (ev && ovl) begin
				overlap_q <= 1'b1;
			end
			if (!ev && !free_q) begin
				free_q <= 1'b1;
			end
		end
	end
	always_ff @(posedge clk) begin
		if (eval_s1 && hit && !found_q) begin
			hit_slot_q <= idx_s1;
			hit_size_q <= es;
			hit_off_q  <= diff;
			hit_perm_q <= ep;
		end
		if (eval_s1 && !ev && !free_q) begin
			free_slot_q <= idx_s1;
		end
	end

	// result and state update
	logic            commit;
	logic [2:0]      res_st;
	logic [IdxW-1:0] res_slot;
	logic [63:0]     res_off, new_bytes, room;
	logic            set_v, clr_v, allowed;
	logic [31:0]     slot_wide;
	assign commit = cmd.finish && !sts.out_busy;
	assign room   = hit_size_q - hit_off_q;
	always_comb begin
		res_st    = ST_MISSING;
		res_slot  = '0;
		res_off   = '0;
		new_bytes = bytes_q;
		set_v     = 1'b0;
		clr_v     = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = hit_slot_q;
		ram_wdata = {addr_q, len_q, perm_q};
		allowed   = (kind_q == KIND_READ) ? hit_perm_q[0] : (skip_q || hit_perm_q[1]);
		unique case (kind_q)
			KIND_MAP: begin
				if (pre_fail_q) begin
					res_st = pre_st_q;
				end else if (overlap_q) begin
					res_st = ST_OVERLAP;
				end else if (!free_q) begin
					res_st = ST_LIMIT;
				end else begin
					res_st    = ST_OK;
					res_slot  = free_slot_q;
					new_bytes = total_q;
					set_v     = 1'b1;
					ram_we    = commit;
					ram_waddr = free_slot_q;
				end
			end
			KIND_UNMAP: begin
				if (found_q) begin
					res_st    = ST_OK;
					res_slot  = hit_slot_q;
					new_bytes = bytes_q - hit_size_q;
					clr_v     = 1'b1;
				end
			end
			KIND_PROTECT: begin
				if (found_q && hit_size_q == len_q) begin
					res_st   = ST_OK;
					res_slot = hit_slot_q;
					ram_we   = commit;
				end
			end
			KIND_READ, KIND_WRITE: begin
				if (len_q == '0) begin
					res_st = ST_OK;
				end else if (found_q && len_q <= room) begin
					res_slot = hit_slot_q;
					if (allowed) begin
						res_st  = ST_OK;
						res_off = hit_off_q;
					end else begin
						res_st = ST_DENIED;
					end
				end
			end
			default: begin
				res_st = ST_MISSING;
			end
		endcase
		slot_wide = 32'(res_slot);
	end

	// limit register, byte total and valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q   <= '1;
			bytes_q <= '0;
			valid_q <= '0;
		end else begin
			if (cfg_we) begin
				max_q <= cfg_wdata;
			end
			if (commit) begin
				bytes_q <= new_bytes;
				if (set_v) begin
					valid_q[res_slot] <= 1'b1;
				end
				if (clr_v) begin
					valid_q[res_slot] <= 1'b0;
				end
			end
		end
	end
	assign max_bytes = max_q;

	// output register
	logic        out_valid_q;
	logic [2:0]  out_st_q;
	logic [3:0]  out_slot_q;
	logic [63:0] out_off_q, out_tot_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (commit) begin
			out_st_q   <= res_st;
			out_slot_q <= slot_wide[3:0];
			out_off_q  <= res_off;
			out_tot_q  <= new_bytes;
		end
	end
	assign out_valid    = out_valid_q;
	assign status       = out_st_q;
	assign slot         = out_slot_q;
	assign offset       = out_off_q;
	assign mapped_total = out_tot_q;

	assign sts.pre_fail = pre_fail_q;
	assign sts.out_busy = out_valid_q && !out_ready;

`ifndef SYNTHESIS
	// results are loaded only into a free output register
	a_commit_room: assert property (@(posedge clk) disable iff (!arst_n)
		commit |-> (!out_valid_q || out_ready))
		else $error("result overwrote pending transfer");
	// a successful map marks its slot valid
	a_map_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && kind_q == KIND_MAP && res_st == ST_OK) |=> valid_q[$past(res_slot)])
		else $error("mapped slot not valid");
	// denied only comes from accesses
	a_denied_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && res_st == ST_DENIED) |-> (kind_q == KIND_READ || kind_q == KIND_WRITE))
		else $error("denied on non-access operation");
`endif
endmodule
`default_nettype wire

// ===== bench/region_map_access_checker_tb.sv =====
// self-checking bench for the region map access checker: directed table, then random ops
// depends on rmac_pkg and region_map_access_checker
`default_nettype none
module region_map_access_checker_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rmac_pkg::*;

	typedef struct {
		logic [2:0]  kind;
		logic [63:0] addr;
		logic [63:0] len;
		logic [7:0]  perms;
		logic        skip;
		logic        known;
		logic [2:0]  st;
	} op_row_t;

	typedef struct {
		logic [2:0]  st;
		logic [3:0]  slot;
		logic [63:0] offset;
		logic [63:0] total;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0, in_ready;
	logic [2:0] kind = '0;
	logic [63:0] address = '0, length = '0;
	logic [7:0] perm_bits = '0;
	logic skip_perm_check = 1'b0;
	logic out_valid, out_ready = 1'b0;
	logic [2:0] status;
	logic [3:0] slot;
	logic [63:0] offset, mapped_total, prdata;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [63:0] pwdata = '0;
	logic pready;

	region_map_access_checker dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// shadow region table
	logic        tbl_valid [16];
	logic [63:0] tbl_base [16];
	logic [63:0] tbl_size [16];
	logic [7:0]  tbl_perms [16];
	logic [63:0] tbl_total;
	logic [63:0] byte_limit;

	verdict_t pending_q[$];
	int errors = 0;
	int n_sent = 0, n_checked = 0;
	int n_ok = 0, n_denied = 0, n_overlap = 0;
	bit hold_long = 0;
	bit done_sending = 0;
	longint cycles = 0;

	function automatic verdict_t predict_op(op_row_t r);
		verdict_t v;
		logic [64:0] fin, sum;
		int hit, free;
		v = '{ST_MISSING, 4'd0, 64'd0, 64'd0};
		hit = -1;
		free = -1;
		case (r.kind)
			KIND_MAP: begin
				fin = {1'b0, r.addr} + {1'b0, r.len};
				sum = {1'b0, tbl_total} + {1'b0, r.len};
				if (r.len == 0) v.st = ST_EMPTY;
				else if (fin[64] || fin[63:0] == 0) v.st = ST_OVERFLOW;
				else if (sum[64] || sum[63:0] > byte_limit) v.st = ST_LIMIT;
				else begin
					for (int i = 0; i < 16; i++)
						if (tbl_valid[i]) begin
							if (hit < 0 && r.addr < tbl_base[i] + tbl_size[i] &&
									tbl_base[i] < fin[63:0])
								hit = i;
						end else if (free < 0) free = i;
					if (hit >= 0) v.st = ST_OVERLAP;
					else if (free < 0) v.st = ST_LIMIT;
					else begin
						tbl_valid[free] = 1'b1;
						tbl_base[free] = r.addr;
						tbl_size[free] = r.len;
						tbl_perms[free] = r.perms;
						tbl_total = sum[63:0];
						v.st = ST_OK;
						v.slot = free[3:0];
					end
				end
			end
			KIND_UNMAP, KIND_PROTECT: begin
				for (int i = 0; i < 16; i++)
					if (hit < 0 && tbl_valid[i] && tbl_base[i] == r.addr) hit = i;
				if (hit >= 0 && r.kind == KIND_UNMAP) begin
					tbl_total -= tbl_size[hit];
					tbl_valid[hit] = 1'b0;
					v.st = ST_OK;
					v.slot = hit[3:0];
				end else if (hit >= 0 && tbl_size[hit] == r.len) begin
					tbl_perms[hit] = r.perms;
					v.st = ST_OK;
					v.slot = hit[3:0];
				end
			end
			KIND_READ, KIND_WRITE: begin
				if (r.len == 0) v.st = ST_OK;
				else begin
					for (int i = 0; i < 16; i++)
						if (hit < 0 && tbl_valid[i] && r.addr >= tbl_base[i] &&
								r.addr - tbl_base[i] < tbl_size[i])
							hit = i;
					if (hit >= 0 &&
							r.len <= tbl_size[hit] - (r.addr - tbl_base[hit])) begin
						v.slot = hit[3:0];
						if ((r.kind == KIND_READ) ? tbl_perms[hit][0] :
								(r.skip || tbl_perms[hit][1])) begin
							v.st = ST_OK;
							v.offset = r.addr - tbl_base[hit];
						end else v.st = ST_DENIED;
					end
				end
			end
			default: ;
		endcase
		v.total = tbl_total;
		return v;
	endfunction

	// valid stays up across back-to-back items and drops only for a gap
	task automatic send_op(op_row_t r);
		verdict_t v;
		int gap;
		gap = $urandom_range(0, 13);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		v = predict_op(r);
		if (r.known && v.st != r.st) begin
			$error("table row status: expected %0d, model %0d", r.st, v.st);
			errors++;
		end
		pending_q.push_back(v);
		in_valid <= 1'b1;
		kind <= r.kind;
		address <= r.addr;
		length <= r.len;
		perm_bits <= r.perms;
		skip_perm_check <= r.skip;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		n_sent++;
	endtask

	task automatic write_limit(logic [63:0] val);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= 4'(REG_MAX_MAPPED) << 3;
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		byte_limit = val;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	// addresses clustered in a small window so ops hit regions
	function automatic op_row_t rand_op();
		op_row_t r;
		int pick;
		r.known = 1'b0;
		r.st = ST_OK;
		r.kind = 3'($urandom_range(0, 4));
		if ($urandom_range(0, 40) == 0) r.kind = 3'($urandom_range(5, 7));
		r.addr = 64'h1000 + 64'($urandom_range(0, 511) * 16);
		r.len = 64'($urandom_range(1, 16) * 16);
		r.perms = 8'($urandom);
		r.skip = 1'($urandom);
		pick = $urandom_range(0, 15);
		if (r.kind != KIND_MAP && tbl_valid[pick] && $urandom_range(0, 3) != 0) begin
			r.addr = tbl_base[pick];
			r.len = tbl_size[pick];
			if (r.kind >= KIND_READ) begin
				r.addr += 64'($urandom_range(0, 15));
				r.len = 64'($urandom_range(0, 20));
			end
		end
		if ($urandom_range(0, 25) == 0) begin
			r.addr = {$urandom, $urandom};
			r.len = {$urandom, $urandom};
		end
		if (r.kind == KIND_UNMAP && $urandom_range(0, 2) != 0) r.kind = KIND_READ;
		return r;
	endfunction

	// result checker
	always @(posedge clk) begin
		verdict_t e;
		if (out_valid && out_ready) begin
			if (pending_q.size() == 0) begin
				$error("result with nothing expected");
				errors++;
			end else begin
				e = pending_q.pop_front();
				n_checked++;
				if (e.st == ST_OK) n_ok++;
				if (e.st == ST_DENIED) n_denied++;
				if (e.st == ST_OVERLAP) n_overlap++;
				if (status !== e.st) begin
					$error("status: expected %0d actual %0d", e.st, status); errors++;
				end
				if (slot !== e.slot) begin
					$error("slot: expected %0d actual %0d", e.slot, slot); errors++;
				end
				if (offset !== e.offset) begin
					$error("offset: expected %h actual %h", e.offset, offset); errors++;
				end
				if (mapped_total !== e.total) begin
					$error("mapped_total: expected %h actual %h", e.total, mapped_total);
					errors++;
				end
			end
		end
	end

	// receiver stalls, with one long hold-off
	always @(posedge clk) begin
		if (!arst_n) out_ready <= 1'b0;
		else if (hold_long) out_ready <= 1'b0;
		else if (out_ready && !out_valid) out_ready <= 1'b1;
		else out_ready <= ($urandom_range(0, 13) < 8);
	end

	initial begin
		int k;
		k = 0;
		forever begin
			@(posedge clk);
			if (n_sent == 400 && k == 0) begin
				k = 1;
				hold_long = 1;
				repeat (300) @(posedge clk);
				hold_long = 0;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > 600000) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	op_row_t dir_tab[$];
	initial begin
		op_row_t r;
		for (int i = 0; i < 16; i++) tbl_valid[i] = 1'b0;
		tbl_total = 0;
		byte_limit = '1;
		dir_tab = '{
			'{KIND_READ, 64'h0, 64'h0, 8'h0, 1'b0, 1'b1, ST_OK},
			'{KIND_READ, 64'h10, 64'h1, 8'h0, 1'b0, 1'b1, ST_MISSING},
			'{KIND_UNMAP, 64'h0, 64'h0, 8'h0, 1'b0, 1'b1, ST_MISSING},
			'{KIND_MAP, 64'h100, 64'h0, 8'h3, 1'b0, 1'b1, ST_EMPTY},
			'{KIND_MAP, '1, 64'h1, 8'h3, 1'b0, 1'b1, ST_OVERFLOW},
			'{KIND_MAP, 64'h1, '1, 8'h3, 1'b0, 1'b1, ST_OVERFLOW},
			'{KIND_MAP, 64'h0, 64'h100, 8'hFF, 1'b0, 1'b1, ST_OK},
			'{KIND_MAP, 64'h80, 64'h100, 8'h3, 1'b0, 1'b1, ST_OVERLAP},
			'{KIND_MAP, 64'h100, 64'h100, 8'h00, 1'b0, 1'b1, ST_OK},
			'{KIND_READ, 64'h110, 64'h10, 8'h0, 1'b0, 1'b0, ST_OK},
			'{KIND_WRITE, 64'h110, 64'h10, 8'h0, 1'b0, 1'b1, ST_DENIED},
			'{KIND_WRITE, 64'h110, 64'hF0, 8'h0, 1'b1, 1'b0, ST_OK},
			'{KIND_READ, 64'hF0, 64'h20, 8'h0, 1'b0, 1'b1, ST_MISSING},
			'{KIND_READ, 64'h20, 64'hE0, 8'h0, 1'b0, 1'b0, ST_OK},
			'{KIND_PROTECT, 64'h100, 64'h80, 8'h3, 1'b0, 1'b1, ST_MISSING},
			'{KIND_PROTECT, 64'h100, 64'h100, 8'h2, 1'b0, 1'b1, ST_OK},
			'{KIND_WRITE, 64'h1FF, 64'h1, 8'h0, 1'b0, 1'b0, ST_OK},
			'{3'd5, 64'h0, 64'h1, 8'h0, 1'b0, 1'b1, ST_MISSING},
			'{3'd7, '1, '1, 8'hFF, 1'b1, 1'b1, ST_MISSING},
			'{KIND_MAP, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 8'h1, 1'b0,
				1'b0, ST_OK},
			'{KIND_READ, '1 - 64'h1, 64'h1, 8'h0, 1'b0, 1'b0, ST_OK},
			'{KIND_MAP, 64'h1000, '1, 8'h1, 1'b0, 1'b1, ST_OVERFLOW},
			'{KIND_UNMAP, 64'h8000_0000_0000_0000, 64'h0, 8'h0, 1'b0, 1'b1, ST_OK},
			'{KIND_UNMAP, 64'h0, 64'h0, 8'h0, 1'b0, 1'b1, ST_OK}
		};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_tab[i]) send_op(dir_tab[i]);
		drain();
		// tiny limit phase: zero then small
		write_limit(64'h0);
		r = '{KIND_MAP, 64'h4000, 64'h1, 8'h3, 1'b0, 1'b1, ST_LIMIT};
		send_op(r);
		drain();
		write_limit(64'h400);
		for (int i = 0; i < 400; i++) send_op(rand_op());
		drain();
		// fill table with small regions to hit the full-table limit
		write_limit('1);
		for (int i = 0; i < 400; i++) begin
			r = rand_op();
			if ($urandom_range(0, 1)) r.kind = KIND_MAP;
			r.len = 64'($urandom_range(1, 4));
			send_op(r);
		end
		drain();
		write_limit(64'h2000);
		for (int i = 0; i < 750; i++) send_op(rand_op());
		done_sending = 1;
		drain();
		$display("ops sent %0d, results checked %0d (ok %0d, denied %0d, overlap %0d)",
			n_sent, n_checked, n_ok, n_denied, n_overlap);
		if (errors == 0 && pending_q.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
`default_nettype wire

// ===== files.f =====
hdl/rmac_pkg.sv
hdl/rmac_ram.sv
hdl/rmac_ctrl.sv
hdl/rmac_dp.sv
hdl/region_map_access_checker.sv
bench/region_map_access_checker_tb.sv
